[rtl/prdt_pkg.sv]
// Shared types, constants and status codes for the periodic release deadline tracker.
package prdt_pkg;

  localparam int PERIOD_BITS_DEF = 32;
  localparam int TIME_W          = 48;
  localparam int CFG_ADDR_W      = 3;

  typedef enum logic [1:0] {
    CMD_ARM      = 2'd0,
    CMD_DISARM   = 2'd1,
    CMD_POLL     = 2'd2,
    CMD_COMPLETE = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_ARMED       = 4'd0,
    ST_ALREADY     = 4'd1,
    ST_DISARMED    = 4'd2,
    ST_WAITING     = 4'd3,
    ST_RELEASED    = 4'd4,
    ST_RAN         = 4'd5,
    ST_SCHED_ERR   = 4'd6,
    ST_BUSY        = 4'd7,
    ST_NOT_RUNNING = 4'd8,
    ST_CFG_INVALID = 4'd9
  } status_t;

  localparam logic [CFG_ADDR_W-1:0] ADDR_PERIOD   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] ADDR_DEADLINE = 3'd4;

  typedef struct packed {
    logic [1:0]        command;
    logic [TIME_W-1:0] time_value;
    logic              clock_ok;
    logic              work_failed;
    logic              halt_req;
  } in_item_t;

  typedef struct packed {
    logic [3:0]        status;
    logic              deadline_missed;
    logic              cycle_failed;
    logic              timing_unusable;
    logic [TIME_W-1:0] scheduled_time;
    logic [TIME_W-1:0] elapsed_ticks;
    logic [TIME_W-1:0] periods_skipped;
    logic [TIME_W-1:0] next_release_time;
  } out_item_t;

  // Work handed from front to back: every result, with a completion whose cycle must be closed flagged.
  typedef struct packed {
    logic              close;      // 1: needs division, 0: result is final
    out_item_t         res;        // final result, or partial for close
    logic [TIME_W-1:0] lag;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_DIV  = 2'd1,
    BK_FIN  = 2'd2,
    BK_OUT  = 2'd3
  } bk_state_t;

endpackage

[rtl/periodic_release_deadline_tracker.sv]
// Top level of the periodic release deadline tracker.
// Usage: program period and deadline through the APB-style port while
// idle, then send command beats on in_ (arm, disarm, poll, work completed).
// Every input beat yields exactly one result beat on out_.
// The front stage decodes each command and updates arm/run state; every
// beat then passes through a one-entry queue to the back stage, which for
// beats that close a cycle divides lag by period with a restoring divider,
// one quotient bit per cycle. A result passes the queue register and the
// back stage's OUT state; one that closes a cycle also passes the DIV and
// FIN states first.
// One item at a time: in_stall stays high while an item sits in the queue
// or back stage or its result waits, so the next beat is taken only once
// the result has left.
// Reset (rst_n low, synchronous) disarms, clears the running flag, zeroes
// the stored release and loads period and deadline with 1000.
// When out_stall is high the result beat holds and new input stalls.
module periodic_release_deadline_tracker #(
  parameter int PERIOD_BITS = prdt_pkg::PERIOD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  prdt_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output prdt_pkg::out_item_t                 out_data,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [prdt_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  localparam int TIME_BITS = prdt_pkg::TIME_W;

  logic [PERIOD_BITS-1:0] period_r, deadline_r;
  logic                   wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  // Configuration registers, masked to the period width.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r   <= PERIOD_BITS'(1000);
      deadline_r <= PERIOD_BITS'(1000);
    end else if (wr) begin
      if (paddr == prdt_pkg::ADDR_PERIOD)   period_r   <= PERIOD_BITS'(pwdata);
      if (paddr == prdt_pkg::ADDR_DEADLINE) deadline_r <= PERIOD_BITS'(pwdata);
    end
  end

  always_comb begin
    case (paddr)
      prdt_pkg::ADDR_PERIOD:   prdata = 32'(period_r);
      prdt_pkg::ADDR_DEADLINE: prdata = 32'(deadline_r);
      default:                 prdata = '0;
    endcase
  end

  // One-entry queue between front and back.
  logic           q_valid_r, q_push, q_pop, busy_back;
  prdt_pkg::job_t q_data_r, q_in;
  logic                 upd_valid, upd_disarm;
  logic [TIME_BITS-1:0] upd_release;

  always_ff @(posedge clk) begin
    if (!rst_n) q_valid_r <= 1'b0;
    else if (q_push) q_valid_r <= 1'b1;
    else if (q_pop) q_valid_r <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (q_push) q_data_r <= q_in;
  end

  prdt_front #(.PERIOD_BITS(PERIOD_BITS)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .period(period_r), .deadline(deadline_r),
    .busy_back, .q_full(q_valid_r), .q_push, .q_data(q_in),
    .upd_valid, .upd_disarm, .upd_release
  );

  prdt_back #(.PERIOD_BITS(PERIOD_BITS)) u_back (
    .clk, .rst_n, .q_valid(q_valid_r), .q_data(q_data_r), .q_pop,
    .period(period_r), .busy(busy_back),
    .upd_valid, .upd_disarm, .upd_release,
    .out_valid, .out_stall, .out_data
  );

endmodule

[rtl/prdt_front.sv]
// Front end: takes commands, updates arm/run state, classifies work for the back end.
module prdt_front #(
  parameter int PERIOD_BITS = prdt_pkg::PERIOD_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  prdt_pkg::in_item_t         in_data,
  input  logic [PERIOD_BITS-1:0]     period,
  input  logic [PERIOD_BITS-1:0]     deadline,
  input  logic                       busy_back,   // back end still owns state
  input  logic                       q_full,
  output logic                       q_push,
  output prdt_pkg::job_t             q_data,
  input  logic                       upd_valid,
  input  logic                       upd_disarm,
  input  logic [prdt_pkg::TIME_W-1:0] upd_release
);

  localparam int TIME_BITS = prdt_pkg::TIME_W;

  logic                 armed_r, armed_nxt;
  logic                 running_r, running_nxt;
  logic [TIME_BITS-1:0] tv;
  logic [TIME_BITS-1:0] nr;
  logic                 cfg_ok;
  logic                 take;

  // Hold off while the back end may still rewrite the stored release.
  assign in_stall = q_full | busy_back;
  assign take     = in_valid & ~in_stall;
  assign q_push   = take;
  assign tv       = in_data.time_value[TIME_BITS-1:0];
  assign cfg_ok   = (period != '0) && (deadline != '0) && (deadline <= period);

  // Stored release; the back end rewrites it when a cycle closes.
  logic [TIME_BITS-1:0] nrel_r, nrel_nxt;
  assign nr = nrel_r;

  // Classify the command.
  always_comb begin
    armed_nxt   = armed_r;
    running_nxt = running_r;
    nrel_nxt    = nrel_r;
    q_data      = '0;
    q_data.res.status = prdt_pkg::ST_ARMED;
    case (prdt_pkg::cmd_t'(in_data.command))
      prdt_pkg::CMD_ARM: begin
        if (armed_r) q_data.res.status = prdt_pkg::ST_ALREADY;
        else if (!cfg_ok) q_data.res.status = prdt_pkg::ST_CFG_INVALID;
        else begin
          nrel_nxt    = tv;
          armed_nxt   = 1'b1;
          running_nxt = 1'b0;
          q_data.res.status = prdt_pkg::ST_ARMED;
        end
      end
      prdt_pkg::CMD_DISARM: begin
        armed_nxt = 1'b0; running_nxt = 1'b0;
        q_data.res.status = prdt_pkg::ST_DISARMED;
      end
      prdt_pkg::CMD_POLL: begin
        if (running_r) q_data.res.status = prdt_pkg::ST_BUSY;
        else if (!armed_r || in_data.halt_req) q_data.res.status = prdt_pkg::ST_WAITING;
        else if (!cfg_ok) begin
          armed_nxt = 1'b0; running_nxt = 1'b0;
          q_data.res.status = prdt_pkg::ST_CFG_INVALID;
        end else if (!in_data.clock_ok) begin
          armed_nxt = 1'b0; running_nxt = 1'b0;
          q_data.res.timing_unusable = 1'b1;
          q_data.res.scheduled_time  = prdt_pkg::TIME_W'(nr);
          q_data.res.status = prdt_pkg::ST_SCHED_ERR;
        end else if (tv < nr) q_data.res.status = prdt_pkg::ST_WAITING;
        else begin
          running_nxt = 1'b1;
          q_data.res.scheduled_time = prdt_pkg::TIME_W'(nr);
          q_data.res.status = prdt_pkg::ST_RELEASED;
        end
      end
      default: begin
        if (!running_r) q_data.res.status = prdt_pkg::ST_NOT_RUNNING;
        else if (!cfg_ok) begin
          armed_nxt = 1'b0; running_nxt = 1'b0;
          q_data.res.status = prdt_pkg::ST_CFG_INVALID;
        end else begin
          running_nxt = 1'b0;
          q_data.res.cycle_failed   = in_data.work_failed;
          q_data.res.scheduled_time = prdt_pkg::TIME_W'(nr);
          if (!in_data.clock_ok) begin
            armed_nxt = 1'b0;
            q_data.res.timing_unusable = 1'b1;
            q_data.res.status = prdt_pkg::ST_SCHED_ERR;
          end else if (tv < nr) begin
            armed_nxt = 1'b0;
            q_data.res.timing_unusable = 1'b1;
            q_data.res.status = prdt_pkg::ST_SCHED_ERR;
          end else begin
            q_data.close = 1'b1;
            q_data.lag   = prdt_pkg::TIME_W'(tv - nr);
            q_data.res.elapsed_ticks   = prdt_pkg::TIME_W'(tv - nr);
            q_data.res.deadline_missed =
              (prdt_pkg::TIME_W'(tv - nr) > prdt_pkg::TIME_W'(deadline));
            q_data.res.status = prdt_pkg::ST_RAN;
          end
        end
      end
    endcase
    q_data.res.next_release_time = prdt_pkg::TIME_W'(nrel_nxt);
  end

  // Take command updates, or the back end's update when it closes a completed run.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r   <= 1'b0;
      running_r <= 1'b0;
      nrel_r    <= '0;
    end else if (take) begin
      armed_r   <= armed_nxt;
      running_r <= running_nxt;
      nrel_r    <= nrel_nxt;
    end else if (upd_valid) begin
      nrel_r  <= upd_release;
      armed_r <= armed_r & ~upd_disarm;
    end
  end

endmodule

[rtl/prdt_back.sv]
// Back end: passes each result to out_ and closes a completed cycle with an iterative divide of lag by period.
module prdt_back #(
  parameter int PERIOD_BITS = prdt_pkg::PERIOD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  prdt_pkg::job_t              q_data,
  output logic                        q_pop,
  input  logic [PERIOD_BITS-1:0]      period,
  output logic                        busy,
  output logic                        upd_valid,
  output logic                        upd_disarm,
  output logic [prdt_pkg::TIME_W-1:0] upd_release,
  output logic                        out_valid,
  input  logic                        out_stall,
  output prdt_pkg::out_item_t         out_data
);

  localparam int TIME_BITS = prdt_pkg::TIME_W;
  localparam int CNT_W = $clog2(TIME_BITS + 1);

  prdt_pkg::bk_state_t  state_r, state_nxt;
  prdt_pkg::out_item_t  res_r;
  logic [TIME_BITS-1:0] quo_r, rem_r, lag_r;
  logic [TIME_BITS-1:0] lag_r_orig;
  logic [CNT_W-1:0]     cnt_r;
  logic [TIME_BITS:0]   trial;
  logic [TIME_BITS-1:0] per;
  logic                 bnd;
  logic [TIME_BITS-1:0] steps;
  logic [TIME_BITS:0]   shift;
  logic [TIME_BITS:0]   sum;
  logic                 ovf;

  assign per   = TIME_BITS'(period);
  assign trial = {rem_r, lag_r[TIME_BITS-1]} - {1'b0, per};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      prdt_pkg::BK_IDLE: if (q_valid) state_nxt = q_data.close ? prdt_pkg::BK_DIV
                                                              : prdt_pkg::BK_OUT;
      prdt_pkg::BK_DIV:  if (cnt_r == CNT_W'(TIME_BITS - 1)) state_nxt = prdt_pkg::BK_FIN;
      prdt_pkg::BK_FIN:  state_nxt = prdt_pkg::BK_OUT;
      prdt_pkg::BK_OUT:  if (!out_stall) state_nxt = prdt_pkg::BK_IDLE;
      default:           state_nxt = prdt_pkg::BK_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    q_pop     = (state_r == prdt_pkg::BK_IDLE) && q_valid;
    out_valid = (state_r == prdt_pkg::BK_OUT);
    busy      = (state_r != prdt_pkg::BK_IDLE) || q_valid;
    out_data  = res_r;
  end

  // Finish: the advance is lag minus remainder, plus one period unless lag is
  // a nonzero exact multiple of period; a zero lag thus advances one period.
  always_comb begin
    steps = quo_r;
    bnd   = (lag_r_orig != '0) && (rem_r == '0);
    shift = {1'b0, lag_r_orig} - {1'b0, rem_r} + (bnd ? '0 : {1'b0, per});
    sum   = {1'b0, TIME_BITS'(res_r.scheduled_time)} + {1'b0, shift[TIME_BITS-1:0]};
    ovf   = shift[TIME_BITS] || sum[TIME_BITS];
  end

  assign upd_valid   = (state_r == prdt_pkg::BK_FIN);
  assign upd_disarm  = ovf;
  assign upd_release = ovf ? TIME_BITS'(res_r.next_release_time) : sum[TIME_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= prdt_pkg::BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Load the job when idle, restoring divide one quotient bit a cycle, then finish the result.
  always_ff @(posedge clk) begin
    case (state_r)
      prdt_pkg::BK_IDLE: begin
        res_r      <= q_data.res;
        lag_r      <= TIME_BITS'(q_data.lag);
        lag_r_orig <= TIME_BITS'(q_data.lag);
        rem_r      <= '0;
        quo_r      <= '0;
        cnt_r      <= '0;
      end
      prdt_pkg::BK_DIV: begin
        lag_r <= lag_r << 1;
        cnt_r <= cnt_r + 1'b1;
        if (!trial[TIME_BITS]) begin
          rem_r <= trial[TIME_BITS-1:0];
          quo_r <= {quo_r[TIME_BITS-2:0], 1'b1};
        end else begin
          rem_r <= {rem_r[TIME_BITS-2:0], lag_r[TIME_BITS-1]};
          quo_r <= {quo_r[TIME_BITS-2:0], 1'b0};
        end
      end
      prdt_pkg::BK_FIN: begin
        if (ovf) begin
          res_r.timing_unusable <= 1'b1;
          res_r.status          <= prdt_pkg::ST_SCHED_ERR;
        end else begin
          res_r.periods_skipped   <= prdt_pkg::TIME_W'(bnd ? steps - 1'b1 : steps);
          res_r.next_release_time <= prdt_pkg::TIME_W'(sum[TIME_BITS-1:0]);
        end
      end
      default: ;
    endcase
  end

  // A result is never shown during the finish step.
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !upd_valid) else $error("result during finish");
  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("result changed");
  // Finish only follows the divide.
  a_fin: assert property (@(posedge clk) disable iff (!rst_n)
    upd_valid |-> $past(state_r) == prdt_pkg::BK_DIV) else $error("finish out of order");

endmodule

[verif/testbench.sv]
// Self-checking testbench for the periodic release deadline tracker.
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [47:0] TMAX = 48'hFFFF_FFFF_FFFF;
  localparam int LIMIT_CYCLES = 2000000;
  localparam int HOLD_CYCLES = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  prdt_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  prdt_pkg::out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [prdt_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  periodic_release_deadline_tracker uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Tracker state as the testbench sees it
  logic [31:0] trk_period = 32'd1000;
  logic [31:0] trk_deadline = 32'd1000;
  logic trk_armed = 1'b0;
  logic trk_running = 1'b0;
  logic [47:0] trk_release = '0;

  prdt_pkg::in_item_t pending_cmds[$];
  prdt_pkg::out_item_t expected_results[$];
  int mismatches = 0;
  int unexpected = 0;
  longint cycles = 0;
  bit send_idle_en = 1'b1;
  bit recv_idle_en = 1'b1;
  bit long_hold = 1'b0;
  bit hold_done = 1'b0;
  int hold_cnt = 0;
  int send_gap = 0;
  int recv_gap = 0;

  function automatic bit timing_ok();
    return trk_period != 0 && trk_deadline != 0 && trk_deadline <= trk_period;
  endfunction

  // Close a released cycle: elapsed, deadline, next boundary, skipped periods
  function automatic logic [3:0] close_cycle(input logic [47:0] sched,
                                             input logic [47:0] done,
                                             inout prdt_pkg::out_item_t r);
    logic [63:0] lag, steps, span, lim, shift, per;
    bit boundary;
    per = {32'd0, trk_period};
    r.scheduled_time = sched;
    if (done < sched) begin
      r.timing_unusable = 1'b1;
      trk_armed = 1'b0;
      trk_running = 1'b0;
      return prdt_pkg::ST_SCHED_ERR;
    end
    lag = {16'd0, done - sched};
    r.elapsed_ticks = lag[47:0];
    r.deadline_missed = lag > {32'd0, trk_deadline};
    steps = lag / per;
    boundary = lag > 0 && (lag % per) == 0;
    lim = {16'd0, TMAX} / per;
    span = boundary ? steps : steps + 1;
    if ((!boundary && steps >= lim) || span > lim ||
        (span * per) > {16'd0, TMAX - sched}) begin
      r.timing_unusable = 1'b1;
      trk_armed = 1'b0;
      trk_running = 1'b0;
      return prdt_pkg::ST_SCHED_ERR;
    end
    shift = span * per;
    trk_release = sched + shift[47:0];
    r.periods_skipped = boundary ? steps[47:0] - 48'd1 : steps[47:0];
    return prdt_pkg::ST_RAN;
  endfunction

  function automatic prdt_pkg::out_item_t track_command(input prdt_pkg::in_item_t c);
    prdt_pkg::out_item_t r;
    logic [3:0] st;
    r = '0;
    case (prdt_pkg::cmd_t'(c.command))
      prdt_pkg::CMD_ARM: begin
        if (trk_armed) st = prdt_pkg::ST_ALREADY;
        else if (!timing_ok()) st = prdt_pkg::ST_CFG_INVALID;
        else begin
          trk_release = c.time_value;
          trk_armed = 1'b1;
          trk_running = 1'b0;
          st = prdt_pkg::ST_ARMED;
        end
      end
      prdt_pkg::CMD_DISARM: begin
        trk_armed = 1'b0;
        trk_running = 1'b0;
        st = prdt_pkg::ST_DISARMED;
      end
      prdt_pkg::CMD_POLL: begin
        if (trk_running) st = prdt_pkg::ST_BUSY;
        else if (!trk_armed || c.halt_req) st = prdt_pkg::ST_WAITING;
        else if (!timing_ok()) begin
          trk_armed = 1'b0;
          st = prdt_pkg::ST_CFG_INVALID;
        end else if (!c.clock_ok) begin
          r.timing_unusable = 1'b1;
          r.scheduled_time = trk_release;
          trk_armed = 1'b0;
          st = prdt_pkg::ST_SCHED_ERR;
        end else if (c.time_value < trk_release) st = prdt_pkg::ST_WAITING;
        else begin
          r.scheduled_time = trk_release;
          trk_running = 1'b1;
          st = prdt_pkg::ST_RELEASED;
        end
      end
      default: begin
        if (!trk_running) st = prdt_pkg::ST_NOT_RUNNING;
        else if (!timing_ok()) begin
          trk_armed = 1'b0;
          trk_running = 1'b0;
          st = prdt_pkg::ST_CFG_INVALID;
        end else begin
          trk_running = 1'b0;
          r.cycle_failed = c.work_failed;
          if (!c.clock_ok) begin
            r.timing_unusable = 1'b1;
            r.scheduled_time = trk_release;
            trk_armed = 1'b0;
            st = prdt_pkg::ST_SCHED_ERR;
          end else st = close_cycle(trk_release, c.time_value, r);
        end
      end
    endcase
    r.status = st;
    r.next_release_time = trk_release;
    return r;
  endfunction

  // Drive command beats; hold payload while stalled
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(track_command(in_data));
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          if (send_idle_en && $urandom_range(0, 9) == 0) begin
            send_gap <= $urandom_range(1, 16) - 1;
            in_valid <= 1'b0;
          end else begin
            in_data <= pending_cmds.pop_front();
            in_valid <= 1'b1;
          end
        end else in_valid <= 1'b0;
      end
    end
  end

  // Count the long receiver hold
  always @(posedge clk) begin
    if (rst_n && long_hold && !hold_done) begin
      if (hold_cnt >= HOLD_CYCLES) hold_done <= 1'b1;
      else hold_cnt <= hold_cnt + 1;
    end
  end

  // Check result beats and throttle the result side
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          unexpected++;
          if (mismatches + unexpected <= 10)
            $display("unexpected result beat: %p", out_data);
        end else begin
          prdt_pkg::out_item_t e;
          e = expected_results.pop_front();
          if (e !== out_data) begin
            mismatches++;
            if (mismatches + unexpected <= 10)
              $display("mismatch: expected %p actual %p", e, out_data);
          end
        end
      end
      if (long_hold && !hold_done) begin
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_stall <= (recv_gap > 1);
      end else if (recv_idle_en && $urandom_range(0, 9) == 0) begin
        recv_gap <= $urandom_range(1, 16);
        out_stall <= 1'b1;
      end else out_stall <= 1'b0;
    end
  end

  // Timeout guard
  always @(posedge clk) begin
    if (cycles > LIMIT_CYCLES) begin
      $display("periodic_release_deadline_tracker test failed");
      $finish;
    end
  end

  function automatic prdt_pkg::in_item_t make_cmd(input prdt_pkg::cmd_t c,
                                                  input logic [47:0] t,
                                                  input bit ok, input bit fl, input bit sp);
    prdt_pkg::in_item_t x;
    x.command = c;
    x.time_value = t;
    x.clock_ok = ok;
    x.work_failed = fl;
    x.halt_req = sp;
    return x;
  endfunction

  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()});
  endfunction

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic reg_write(input logic [prdt_pkg::CFG_ADDR_W-1:0] a, input logic [31:0] v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= a;
    pwdata <= v;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (a == prdt_pkg::ADDR_PERIOD) trk_period = v;
    else trk_deadline = v;
  endtask

  // One cycle: arm, polls, release, completion with random lag, then disarm
  task automatic queue_cycle(input logic [47:0] base);
    logic [47:0] lag;
    int n;
    pending_cmds.push_back(make_cmd(prdt_pkg::CMD_ARM, base, 1'b1, 1'b0, 1'b0));
    n = $urandom_range(0, 2);
    repeat (n) pending_cmds.push_back(make_cmd(prdt_pkg::CMD_POLL,
                                               base - $urandom_range(0, 50),
                                               1'b1, 1'b0, $urandom_range(0, 1)));
    pending_cmds.push_back(make_cmd(prdt_pkg::CMD_POLL, base + $urandom_range(0, 20),
                                    1'b1, 1'b0, 1'b0));
    case ($urandom_range(0, 5))
      0: lag = 0;
      1: lag = trk_period;
      2: lag = trk_period * $urandom_range(1, 5);
      3: lag = $urandom_range(0, 3 * trk_period);
      4: lag = rand48();
      default: lag = trk_deadline + $urandom_range(0, 2);
    endcase
    if ($urandom_range(0, 15) == 0) lag = -48'd1 - $urandom_range(0, 5);
    pending_cmds.push_back(make_cmd(prdt_pkg::CMD_COMPLETE, base + lag,
                                    $urandom_range(0, 15) != 0,
                                    $urandom_range(0, 1), $urandom_range(0, 1)));
    if ($urandom_range(0, 3) == 0)
      pending_cmds.push_back(make_cmd(prdt_pkg::CMD_POLL, rand48(), $urandom_range(0, 1),
                                      1'b0, 1'b0));
    pending_cmds.push_back(make_cmd(prdt_pkg::CMD_DISARM, rand48(), 1'b1, 1'b0, 1'b0));
  endtask

  task automatic queue_noise(input int n);
    repeat (n) pending_cmds.push_back(make_cmd(prdt_pkg::cmd_t'($urandom_range(0, 3)),
                                               rand48(),
                                               $urandom_range(0, 1), $urandom_range(0, 1),
                                               $urandom_range(0, 1)));
  endtask

  task automatic random_phase(input int ncycles);
    repeat (ncycles) begin
      if ($urandom_range(0, 4) == 0) queue_noise($urandom_range(1, 4));
      else if ($urandom_range(0, 7) == 0) queue_cycle(TMAX - $urandom_range(0, 3000));
      else queue_cycle(rand48() >> $urandom_range(0, 40));
    end
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: defaults, busy, not running, overflow, backwards, clock faults
    pending_cmds.push_back(make_cmd(prdt_pkg::CMD_COMPLETE, 48'd0, 1'b1, 1'b0, 1'b0));
    pending_cmds.push_back(make_cmd(prdt_pkg::CMD_POLL, 48'd0, 1'b1, 1'b0, 1'b0));
    pending_cmds.push_back(make_cmd(prdt_pkg::CMD_ARM, 48'd100, 1'b1, 1'b0, 1'b0));
    pending_cmds.push_back(make_cmd(prdt_pkg::CMD_ARM, 48'd5, 1'b1, 1'b0, 1'b0));
    pending_cmds.push_back(make_cmd(prdt_pkg::CMD_POLL, 48'd99, 1'b1, 1'b0, 1'b0));
    pending_cmds.push_back(make_cmd(prdt_pkg::CMD_POLL, 48'd200, 1'b1, 1'b0, 1'b1));
    pending_cmds.push_back(make_cmd(prdt_pkg::CMD_POLL, 48'd100, 1'b1, 1'b0, 1'b0));
    pending_cmds.push_back(make_cmd(prdt_pkg::CMD_POLL, 48'd100, 1'b1, 1'b0, 1'b0));
    pending_cmds.push_back(make_cmd(prdt_pkg::CMD_COMPLETE, 48'd2100, 1'b1, 1'b1, 1'b0));
    pending_cmds.push_back(make_cmd(prdt_pkg::CMD_POLL, 48'd2100, 1'b1, 1'b0, 1'b0));
    pending_cmds.push_back(make_cmd(prdt_pkg::CMD_COMPLETE, 48'd2000, 1'b1, 1'b0, 1'b0));
    pending_cmds.push_back(make_cmd(prdt_pkg::CMD_POLL, TMAX, 1'b0, 1'b0, 1'b0));
    pending_cmds.push_back(make_cmd(prdt_pkg::CMD_ARM, TMAX - 48'd10, 1'b1, 1'b0, 1'b0));
    pending_cmds.push_back(make_cmd(prdt_pkg::CMD_POLL, TMAX, 1'b1, 1'b0, 1'b0));
    pending_cmds.push_back(make_cmd(prdt_pkg::CMD_COMPLETE, TMAX, 1'b1, 1'b0, 1'b0));
    pending_cmds.push_back(make_cmd(prdt_pkg::CMD_ARM, 48'd0, 1'b1, 1'b0, 1'b0));
    pending_cmds.push_back(make_cmd(prdt_pkg::CMD_POLL, 48'd0, 1'b1, 1'b0, 1'b0));
    pending_cmds.push_back(make_cmd(prdt_pkg::CMD_COMPLETE, 48'd0, 1'b0, 1'b1, 1'b1));
    pending_cmds.push_back(make_cmd(prdt_pkg::CMD_DISARM, TMAX, 1'b0, 1'b1, 1'b1));
    wait_drained();

    random_phase(40);

    // Long receiver hold while the sender keeps offering beats
    long_hold = 1'b1;
    queue_noise(30);
    wait_drained();
    long_hold = 1'b0;

    // Invalid setting: deadline above period, then zero period and deadline
    reg_write(prdt_pkg::ADDR_DEADLINE, 32'd2000);
    queue_noise(20);
    wait_drained();
    reg_write(prdt_pkg::ADDR_PERIOD, 32'd0);
    reg_write(prdt_pkg::ADDR_DEADLINE, 32'd0);
    queue_noise(20);
    wait_drained();

    // Extremes and ordinary settings
    reg_write(prdt_pkg::ADDR_PERIOD, 32'd1);
    reg_write(prdt_pkg::ADDR_DEADLINE, 32'd1);
    random_phase(25);
    reg_write(prdt_pkg::ADDR_PERIOD, 32'hFFFF_FFFF);
    reg_write(prdt_pkg::ADDR_DEADLINE, 32'hFFFF_FFFF);
    random_phase(25);
    reg_write(prdt_pkg::ADDR_PERIOD, $urandom_range(2, 5000));
    reg_write(prdt_pkg::ADDR_DEADLINE, $urandom_range(1, trk_period));
    random_phase(35);

    // Valid at setup with an armed job, then invalidated mid-cycle
    reg_write(prdt_pkg::ADDR_PERIOD, 32'd50);
    reg_write(prdt_pkg::ADDR_DEADLINE, 32'd20);
    pending_cmds.push_back(make_cmd(prdt_pkg::CMD_ARM, 48'd10, 1'b1, 1'b0, 1'b0));
    pending_cmds.push_back(make_cmd(prdt_pkg::CMD_POLL, 48'd10, 1'b1, 1'b0, 1'b0));
    wait_drained();
    reg_write(prdt_pkg::ADDR_PERIOD, 32'd5);
    pending_cmds.push_back(make_cmd(prdt_pkg::CMD_COMPLETE, 48'd30, 1'b1, 1'b0, 1'b0));
    pending_cmds.push_back(make_cmd(prdt_pkg::CMD_ARM, 48'd10, 1'b1, 1'b0, 1'b0));
    wait_drained();
    reg_write(prdt_pkg::ADDR_DEADLINE, 32'd5);
    pending_cmds.push_back(make_cmd(prdt_pkg::CMD_ARM, 48'd10, 1'b1, 1'b0, 1'b0));
    wait_drained();
    reg_write(prdt_pkg::ADDR_DEADLINE, 32'd9);
    pending_cmds.push_back(make_cmd(prdt_pkg::CMD_POLL, 48'd10, 1'b1, 1'b0, 1'b0));
    pending_cmds.push_back(make_cmd(prdt_pkg::CMD_DISARM, 48'd0, 1'b1, 1'b0, 1'b0));
    wait_drained();

    // Final part without idling
    reg_write(prdt_pkg::ADDR_DEADLINE, 32'd3);
    send_idle_en = 1'b0;
    recv_idle_en = 1'b0;
    random_phase(35);

    if (mismatches == 0 && unexpected == 0 && expected_results.size() == 0) begin
      $display("periodic_release_deadline_tracker test passed");
    end else begin
      $display("periodic_release_deadline_tracker test failed");
    end
    $finish;
  end

endmodule
